/* hw/rtl/swu_pkg.sv */
// Shared types and constants for the SOM weight vector update block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package swu_pkg;

	localparam int DIMENSIONS_DEF = 64;

	localparam int KIND_W      = 3;
	localparam int DIM_INDEX_W = 6;
	localparam int COORD_W     = 16;
	localparam int RATE_W      = 16;
	localparam int VALUE_W     = 39;
	localparam int ACC_W       = 38;
	localparam int ROOT_W      = ACC_W / 2;
	localparam int REM_W       = ROOT_W + 2;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int DELTA_W     = PROD_W - RATE_W;
	localparam int SUM16_W     = DELTA_W + 1;
	localparam int QSQ_W       = 2 * COORD_W;

	localparam logic [ACC_W-1:0]   ACC_MAX   = '1;
	localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD   = 3'd0,
		KIND_DIST   = 3'd1,
		KIND_UPDATE = 3'd2,
		KIND_ERASE  = 3'd3,
		KIND_QUERY  = 3'd4
	} kind_t;

	typedef struct packed {
		logic accept;
		logic load_wr;
		logic erase;
		logic exec;
		logic exec_upd;
		logic upd_write;
		logic dist_acc;
		logic dist_last;
		logic sqrt_step;
		logic q_start;
		logic q_issue;
		logic emit;
		logic emit_query;
	} swu_cmd_t;

	typedef struct packed {
		logic out_free;
	} swu_stat_t;

	function automatic logic signed [COORD_W-1:0] sat16(input logic signed [SUM16_W-1:0] v);
		logic signed [SUM16_W-1:0] hi;
		logic signed [SUM16_W-1:0] lo;
		hi = SUM16_W'(32767);
		lo = -SUM16_W'(32768);
		if (v > hi) begin
			return 16'sh7FFF;
		end else if (v < lo) begin
			return 16'sh8000;
		end else begin
			return v[COORD_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/swu_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module swu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/swu_datapath.sv */
// Datapath: coordinate and offset memories, shared multiplier, accumulator,
// bit-serial square root, offset query pipeline and output register. Uses swu_pkg, swu_ram.
`timescale 1ns / 1ps
`default_nettype none

module swu_datapath import swu_pkg::*; #(
	parameter int DEPTH = DIMENSIONS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire swu_cmd_t                  cmd,
	output swu_stat_t                      stat,
	input  wire logic [AW-1:0]             q_addr,
	input  wire logic [DIM_INDEX_W-1:0]    dim_index,
	input  wire logic signed [COORD_W-1:0] coord_value,
	input  wire logic [RATE_W-1:0]         learn_rate,
	input  wire logic                      out_stall,
	output logic                           out_valid,
	output logic [VALUE_W-1:0]             value,
	output logic                           is_offset_sum
);

	localparam logic [DIM_INDEX_W:0] DEPTH_V = (DIM_INDEX_W + 1)'(DEPTH);

	// latched transaction fields
	logic [DIM_INDEX_W-1:0]    idx_q;
	logic                      idx_ok_q;
	logic signed [COORD_W-1:0] point_q;
	logic [RATE_W-1:0]         rate_q;
	logic                      idx_ok_in;

	// memories
	logic                      coord_we;
	logic [AW-1:0]             coord_waddr;
	logic [COORD_W-1:0]        coord_wdata;
	logic [COORD_W-1:0]        coord_rdata;
	logic                      off_we;
	logic [COORD_W-1:0]        off_rdata;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic [DEPTH-1:0]          off_vld_q;
	logic                      off_vld_rd_q;
	logic signed [COORD_W-1:0] coord_rd;
	logic signed [COORD_W-1:0] off_rd;

	// element arithmetic
	logic signed [DIFF_W-1:0]  d_dist;
	logic signed [DIFF_W-1:0]  d_upd;
	logic signed [DIFF_W-1:0]  mul_a;
	logic signed [DIFF_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [DELTA_W-1:0] delta;
	logic signed [SUM16_W-1:0] coord_sum;
	logic signed [SUM16_W-1:0] off_sum;
	logic signed [COORD_W-1:0] coord_new;
	logic signed [COORD_W-1:0] off_new;
	logic [ACC_W:0]            acc_sum;
	logic [ACC_W-1:0]          acc_next;
	logic [ACC_W-1:0]          acc_q;

	// square root
	logic [ACC_W-1:0]          rt_x_q;
	logic [REM_W-1:0]          rt_rem_q;
	logic [ROOT_W-1:0]         rt_root_q;
	logic [REM_W+1:0]          rt_cat;
	logic [REM_W+1:0]          rt_trial;
	logic [REM_W+1:0]          rt_diff;

	// offset query
	logic                      qv_s1;
	logic                      qv_s2;
	logic signed [QSQ_W-1:0]   qsq;
	logic [QSQ_W-1:0]          qsq_s2;
	logic [VALUE_W:0]          qsum_next;
	logic [VALUE_W-1:0]        qsum_q;

	// output register
	logic                      out_valid_q;
	logic [VALUE_W-1:0]        value_q;
	logic                      is_off_q;

	assign idx_ok_in = {1'b0, dim_index} < DEPTH_V;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q    <= dim_index;
			idx_ok_q <= idx_ok_in;
			point_q  <= coord_value;
			rate_q   <= learn_rate;
		end
	end

	// memory ports
	assign rd_en   = cmd.accept || cmd.q_issue;
	assign rd_addr = cmd.q_issue ? q_addr : dim_index[AW-1:0];

	always_comb begin
		if (cmd.load_wr) begin
			coord_we    = idx_ok_in;
			coord_waddr = dim_index[AW-1:0];
			coord_wdata = coord_value;
		end else begin
			coord_we    = cmd.upd_write && idx_ok_q;
			coord_waddr = idx_q[AW-1:0];
			coord_wdata = coord_new;
		end
	end

	assign off_we = cmd.upd_write && idx_ok_q;

	swu_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_coord_ram (
		.clk   (clk),
		.we    (coord_we),
		.waddr (coord_waddr),
		.wdata (coord_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (coord_rdata)
	);

	swu_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_offset_ram (
		.clk   (clk),
		.we    (off_we),
		.waddr (idx_q[AW-1:0]),
		.wdata (off_new),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (off_rdata)
	);

	// an offset entry not written since the last erase reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_vld_q <= '0;
		end else if (cmd.erase) begin
			off_vld_q <= '0;
		end else if (off_we) begin
			off_vld_q[idx_q[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			off_vld_rd_q <= off_vld_q[rd_addr];
		end
	end

	assign coord_rd = coord_rdata;
	assign off_rd   = off_vld_rd_q ? off_rdata : '0;

	// shared multiplier: squared difference or rate times difference
	assign d_dist = {coord_rd[COORD_W-1], coord_rd} - {point_q[COORD_W-1], point_q};
	assign d_upd  = {point_q[COORD_W-1], point_q} - {coord_rd[COORD_W-1], coord_rd};
	assign mul_a  = cmd.exec_upd ? $signed({1'b0, rate_q}) : d_dist;
	assign mul_b  = cmd.exec_upd ? d_upd : d_dist;
	assign mul_p  = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			// an out-of-range distance element adds nothing
			prod_q <= (cmd.exec_upd || idx_ok_q) ? mul_p : '0;
		end
	end

	// arithmetic shift floors toward minus infinity
	assign delta     = prod_q[PROD_W-1:RATE_W];
	assign coord_sum = {{(SUM16_W - COORD_W){coord_rd[COORD_W-1]}}, coord_rd}
		+ {delta[DELTA_W-1], delta};
	assign off_sum   = {{(SUM16_W - COORD_W){off_rd[COORD_W-1]}}, off_rd}
		+ {delta[DELTA_W-1], delta};
	assign coord_new = sat16(coord_sum);
	assign off_new   = sat16(off_sum);

	assign acc_sum  = {1'b0, acc_q} + (ACC_W + 1)'(prod_q[PROD_W-2:0]);
	assign acc_next = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.dist_acc) begin
			acc_q <= cmd.dist_last ? '0 : acc_next;
		end
	end

	// square root, one result bit per step
	assign rt_cat   = {rt_rem_q, rt_x_q[ACC_W-1 -: 2]};
	assign rt_trial = (REM_W + 2)'({rt_root_q, 2'b01});
	assign rt_diff  = rt_cat - rt_trial;

	always_ff @(posedge clk) begin
		if (cmd.dist_acc && cmd.dist_last) begin
			rt_x_q    <= acc_next;
			rt_rem_q  <= '0;
			rt_root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rt_x_q <= {rt_x_q[ACC_W-3:0], 2'b00};
			if (rt_cat >= rt_trial) begin
				rt_rem_q  <= rt_diff[REM_W-1:0];
				rt_root_q <= {rt_root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rt_rem_q  <= rt_cat[REM_W-1:0];
				rt_root_q <= {rt_root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	// offset query: read, square, accumulate
	assign qsq       = off_rd * off_rd;
	assign qsum_next = {1'b0, qsum_q} + (VALUE_W + 1)'(qsq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s1 <= 1'b0;
			qv_s2 <= 1'b0;
		end else begin
			qv_s1 <= cmd.q_issue;
			qv_s2 <= qv_s1;
		end
	end

	always_ff @(posedge clk) begin
		qsq_s2 <= qsq;
		if (cmd.q_start) begin
			qsum_q <= '0;
		end else if (qv_s2) begin
			qsum_q <= qsum_next[VALUE_W] ? VALUE_MAX : qsum_next[VALUE_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q  <= cmd.emit_query ? qsum_q : VALUE_W'(rt_root_q);
			is_off_q <= cmd.emit_query;
		end
	end

	assign stat.out_free  = !out_valid_q || !out_stall;
	assign out_valid      = out_valid_q;
	assign value          = value_q;
	assign is_offset_sum  = is_off_q;

endmodule

`default_nettype wire

/* hw/rtl/swu_ctrl.sv */
// Controller: sequences each transaction through the datapath.
// Uses swu_pkg for the operation codes and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module swu_ctrl import swu_pkg::*; #(
	parameter int DEPTH = DIMENSIONS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int QCW = $clog2(DEPTH + 2)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic              last_element,
	input  wire swu_stat_t         stat,
	output swu_cmd_t               cmd,
	output logic [AW-1:0]          q_addr
);

	localparam int SCW = $clog2(ROOT_W);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EXEC  = 6'b000010,
		ST_WRITE = 6'b000100,
		ST_SQRT  = 6'b001000,
		ST_QUERY = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [KIND_W-1:0] kind_q;
	logic              last_q;
	logic [SCW-1:0]    sq_cnt_q;
	logic [QCW-1:0]    q_cnt_q;
	logic              accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign q_addr   = q_cnt_q[AW-1:0];

	always_comb begin
		cmd        = '0;
		cmd.accept = accept;
		state_d    = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						KIND_LOAD:   cmd.load_wr = 1'b1;
						KIND_ERASE:  cmd.erase = 1'b1;
						KIND_DIST,
						KIND_UPDATE: state_d = ST_EXEC;
						KIND_QUERY: begin
							cmd.q_start = 1'b1;
							state_d     = ST_QUERY;
						end
						default: ;
					endcase
				end
			end
			ST_EXEC: begin
				cmd.exec     = 1'b1;
				cmd.exec_upd = (kind_q == KIND_UPDATE);
				state_d      = ST_WRITE;
			end
			ST_WRITE: begin
				if (kind_q == KIND_UPDATE) begin
					cmd.upd_write = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.dist_acc  = 1'b1;
					cmd.dist_last = last_q;
					state_d       = last_q ? ST_SQRT : ST_IDLE;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sq_cnt_q == SCW'(ROOT_W - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_QUERY: begin
				// issue reads, then let the last two entries drain
				cmd.q_issue = (q_cnt_q < QCW'(DEPTH));
				if (q_cnt_q == QCW'(DEPTH + 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_query = (kind_q == KIND_QUERY);
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sq_cnt_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.dist_last) begin
				sq_cnt_q <= '0;
			end else if (cmd.sqrt_step) begin
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end
			if (cmd.q_start) begin
				q_cnt_q <= '0;
			end else if (state_q == ST_QUERY) begin
				q_cnt_q <= q_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			last_q <= last_element;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/som_weight_vector_update.sv */
// Weight vector of one self-organizing-map neuron with distance, update and offset query.
// Top level: joins swu_ctrl and swu_datapath; uses swu_pkg.
//
// Input channel: in_valid / in_stall with fields kind, dim_index, coord_value,
// learn_rate, last_element; a transaction is taken when in_valid is high and
// in_stall is low. Output channel: out_valid / out_stall with value and
// is_offset_sum; at most one result per input transaction.
// One transaction is in work at a time; in_stall is high while it runs.
//   load coord, erase offsets, unused kinds: done when the transaction is accepted
//   distance or update element: memory read, multiply, write back
//   distance element with last mark: as above, then 19 square root steps, then
//   load the output register
//   offset query: accept, DEPTH offset reads at one per cycle, then drain the
//   square and sum stages and load the output register,
//   DEPTH = min(DIMENSIONS, 64)
// The output register holds one result; a new transaction is accepted while it
// waits. A result-producing transaction that finishes while the receiver still
// stalls the previous result waits until the register frees.
// Reset: offsets read as zero, the accumulator is zero, the output register is
// empty. Coordinates are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module som_weight_vector_update import swu_pkg::*; #(
	parameter int DIMENSIONS = DIMENSIONS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [KIND_W-1:0]         kind,
	input  wire logic [DIM_INDEX_W-1:0]    dim_index,
	input  wire logic signed [COORD_W-1:0] coord_value,
	input  wire logic [RATE_W-1:0]         learn_rate,
	input  wire logic                      last_element,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [VALUE_W-1:0]             value,
	output logic                           is_offset_sum
);

	localparam int DEPTH = (DIMENSIONS < 2 ** DIM_INDEX_W) ? DIMENSIONS : 2 ** DIM_INDEX_W;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	swu_cmd_t      cmd;
	swu_stat_t     stat;
	logic [AW-1:0] q_addr;

	swu_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.last_element (last_element),
		.stat         (stat),
		.cmd          (cmd),
		.q_addr       (q_addr)
	);

	swu_datapath #(.DEPTH(DEPTH)) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.q_addr        (q_addr),
		.dim_index     (dim_index),
		.coord_value   (coord_value),
		.learn_rate    (learn_rate),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.value         (value),
		.is_offset_sum (is_offset_sum)
	);

endmodule

`default_nettype wire

/* tb/tb_som_weight_vector_update.sv */
// Self-checking testbench for som_weight_vector_update: directed and random weight operations
// checked against a predictor of coordinates, offsets and the distance accumulator.
// Depends on swu_pkg and the som_weight_vector_update RTL.
`timescale 1ns / 1ps

module tb_som_weight_vector_update;
	import swu_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 90;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               offset_sum;
	} norm_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [KIND_W-1:0]         kind = KIND_LOAD;
	logic [DIM_INDEX_W-1:0]    dim_index = '0;
	logic signed [COORD_W-1:0] coord_value = '0;
	logic [RATE_W-1:0]         learn_rate = '0;
	logic                      last_element = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [VALUE_W-1:0]        value;
	logic                      is_offset_sum;

	// predictor state
	logic signed [COORD_W-1:0] coord_mem [DIMENSIONS_DEF];
	logic signed [COORD_W-1:0] offset_mem [DIMENSIONS_DEF];
	longint unsigned           square_sum;
	bit                        coord_loaded [DIMENSIONS_DEF];
	int                        loaded_dims [$];

	norm_result_t pending_norms [$];
	norm_result_t next_norm;
	int           mismatch_count = 0;
	int           quiet_cycles = 0;
	bit           idle_off = 1'b0;
	int           gap_pct = 15;
	int           stall_pct = 15;

	som_weight_vector_update #(
		.DIMENSIONS(DIMENSIONS_DEF)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.dim_index(dim_index),
		.coord_value(coord_value),
		.learn_rate(learn_rate),
		.last_element(last_element),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.is_offset_sum(is_offset_sum)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic signed [COORD_W-1:0] clamp_q88(input longint v);
		if (v > 32767) begin
			return 16'sh7FFF;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return v[COORD_W-1:0];
	endfunction

	function automatic longint unsigned floor_root(input longint unsigned x);
		longint unsigned root;
		longint unsigned trial;
		int b;
		root = 0;
		for (b = 20; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= x) begin
				root = trial;
			end
		end
		return root;
	endfunction

	task automatic predict_weight_op(input logic [KIND_W-1:0] op, input logic [DIM_INDEX_W-1:0] dim,
			input logic signed [COORD_W-1:0] point, input logic [RATE_W-1:0] rate,
			input logic last);
		longint          diff;
		longint          step;
		longint unsigned total;
		norm_result_t    res;
		case (op)
			KIND_LOAD: begin
				if (dim < DIMENSIONS_DEF) begin
					coord_mem[dim] = point;
				end
			end
			KIND_DIST: begin
				if (dim < DIMENSIONS_DEF) begin
					diff = longint'(coord_mem[dim]) - longint'(point);
					total = square_sum + longint'(diff * diff);
					square_sum = (total > ACC_MAX) ? longint'(ACC_MAX) : total;
				end
				if (last) begin
					res.value = VALUE_W'(floor_root(square_sum));
					res.offset_sum = 1'b0;
					pending_norms.push_back(res);
					square_sum = 0;
				end
			end
			KIND_UPDATE: begin
				if (dim < DIMENSIONS_DEF) begin
					diff = longint'(point) - longint'(coord_mem[dim]);
					// arithmetic shift floors negative products
					step = (longint'(rate) * diff) >>> 16;
					coord_mem[dim] = clamp_q88(longint'(coord_mem[dim]) + step);
					offset_mem[dim] = clamp_q88(longint'(offset_mem[dim]) + step);
				end
			end
			KIND_ERASE: begin
				foreach (offset_mem[i]) begin
					offset_mem[i] = '0;
				end
			end
			KIND_QUERY: begin
				total = 0;
				foreach (offset_mem[i]) begin
					total += longint'(offset_mem[i]) * longint'(offset_mem[i]);
					if (total > VALUE_MAX) begin
						total = VALUE_MAX;
					end
				end
				res.value = VALUE_W'(total);
				res.offset_sum = 1'b1;
				pending_norms.push_back(res);
			end
			default: begin
			end
		endcase
	endtask

	// Drive one transaction, hold it until accepted, then predict its outcome.
	task automatic issue_op(input logic [KIND_W-1:0] op, input logic [DIM_INDEX_W-1:0] dim,
			input logic signed [COORD_W-1:0] point, input logic [RATE_W-1:0] rate,
			input logic last);
		if (!idle_off && $urandom_range(1, 100) <= gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= op;
		dim_index    <= dim;
		coord_value  <= point;
		learn_rate   <= rate;
		last_element <= last;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (op == KIND_LOAD && !coord_loaded[dim]) begin
			coord_loaded[dim] = 1'b1;
			loaded_dims.push_back(dim);
		end
		predict_weight_op(op, dim, point, rate, last);
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 15))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic logic [RATE_W-1:0] rand_rate();
		case ($urandom_range(0, 15))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h0001;
			3: return 16'h8000;
			default: return RATE_W'($urandom);
		endcase
	endfunction

	function automatic logic [DIM_INDEX_W-1:0] pick_loaded_dim();
		return DIM_INDEX_W'(loaded_dims[$urandom_range(0, loaded_dims.size() - 1)]);
	endfunction

	// One random non-distance transaction; the last mark is noise here.
	task automatic issue_filler_op();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			issue_op(KIND_UPDATE, pick_loaded_dim(), rand_coord(), rand_rate(), 1'($urandom));
		end else if (roll < 75) begin
			issue_op(KIND_LOAD, DIM_INDEX_W'($urandom), rand_coord(), rand_rate(), 1'($urandom));
		end else if (roll < 82) begin
			issue_op(KIND_ERASE, DIM_INDEX_W'($urandom), rand_coord(), rand_rate(),
				1'($urandom));
		end else begin
			issue_op(KIND_QUERY, DIM_INDEX_W'($urandom), rand_coord(), rand_rate(),
				1'($urandom));
		end
	endtask

	task automatic test_load_and_spare_kinds();
		logic [KIND_W-1:0] k;
		issue_op(KIND_LOAD, 6'd0, 16'sh7FFF, 16'hFFFF, 1'b0);
		issue_op(KIND_LOAD, 6'd1, 16'sh8000, 16'h0000, 1'b1);
		issue_op(KIND_LOAD, 6'd2, 16'sh0000, 16'hFFFF, 1'b0);
		issue_op(KIND_LOAD, 6'd63, 16'sh0180, 16'h0000, 1'b0);
		for (k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST && k != '0; k++) begin
			issue_op(k, 6'd63, 16'shFFFF, 16'hFFFF, 1'b1);
		end
	endtask

	task automatic test_distance_vectors();
		issue_op(KIND_DIST, 6'd0, 16'sh8000, 16'h0000, 1'b1);
		issue_op(KIND_DIST, 6'd1, 16'sh7FFF, 16'hFFFF, 1'b0);
		issue_op(KIND_DIST, 6'd2, 16'sh0000, 16'h0000, 1'b0);
		issue_op(KIND_DIST, 6'd63, 16'sh0180, 16'h0000, 1'b1);
		issue_op(KIND_DIST, 6'd2, 16'sh0000, 16'h0000, 1'b1);
		issue_op(KIND_DIST, 6'd63, 16'sh7FFF, 16'hFFFF, 1'b1);
	endtask

	task automatic test_update_and_offsets();
		issue_op(KIND_QUERY, 6'd0, 16'sh0000, 16'h0000, 1'b0);
		issue_op(KIND_LOAD, 6'd3, 16'sh7FFF, 16'h0000, 1'b0);
		// full-rate swing drives the offset into saturation
		issue_op(KIND_UPDATE, 6'd3, 16'sh8000, 16'hFFFF, 1'b0);
		issue_op(KIND_UPDATE, 6'd3, 16'sh7FFF, 16'hFFFF, 1'b0);
		issue_op(KIND_UPDATE, 6'd2, 16'sh0101, 16'h0000, 1'b0);
		issue_op(KIND_UPDATE, 6'd2, 16'shFFFF, 16'h0001, 1'b1);
		issue_op(KIND_UPDATE, 6'd1, 16'sh7FFF, 16'h8000, 1'b0);
		issue_op(KIND_QUERY, 6'd63, 16'shFFFF, 16'hFFFF, 1'b1);
		issue_op(KIND_ERASE, 6'd63, 16'shFFFF, 16'hFFFF, 1'b1);
		issue_op(KIND_QUERY, 6'd0, 16'sh0000, 16'h0000, 1'b0);
	endtask

	task automatic test_accumulator_saturation();
		int e;
		issue_op(KIND_LOAD, 6'd0, 16'sh7FFF, 16'h0000, 1'b0);
		// 66 maximal squares exceed the 38-bit accumulator
		for (e = 0; e < 66; e++) begin
			issue_op(KIND_DIST, 6'd0, 16'sh8000, 16'h0000, 1'(e == 65));
		end
	endtask

	task automatic test_random_mix(input int count);
		int issued;
		int roll;
		int len;
		int e;
		issued = 0;
		while (issued < count) begin
			if ($urandom_range(0, 39) == 0) begin
				gap_pct = $urandom_range(0, 2) * 15;
				stall_pct = $urandom_range(0, 2) * 15;
			end
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70)
					: $urandom_range(1, 8);
				for (e = 0; e < len; e++) begin
					// interleave other work into the vector now and then
					if ($urandom_range(0, 5) == 0) begin
						issue_filler_op();
						issued++;
					end
					issue_op(KIND_DIST, pick_loaded_dim(), rand_coord(), rand_rate(),
						1'(e == len - 1));
					issued++;
				end
			end else if (roll < 96) begin
				issue_filler_op();
				issued++;
			end else begin
				issue_op(KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
					DIM_INDEX_W'($urandom), rand_coord(), rand_rate(), 1'($urandom));
			end
		end
	endtask

	task automatic test_back_to_back(input int count);
		idle_off = 1'b1;
		test_random_mix(count);
	endtask

	always begin
		@(posedge clk);
		if (!idle_off && $urandom_range(1, 100) <= stall_pct) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_norms.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual value %0d sum %0b",
					$time, value, is_offset_sum);
				mismatch_count++;
			end else begin
				next_norm = pending_norms.pop_front();
				if (value !== next_norm.value) begin
					$display("%0t: value mismatch, expected %0d, actual %0d",
						$time, next_norm.value, value);
					mismatch_count++;
				end
				if (is_offset_sum !== next_norm.offset_sum) begin
					$display("%0t: is_offset_sum mismatch, expected %0b, actual %0b",
						$time, next_norm.offset_sum, is_offset_sum);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
		begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		foreach (coord_mem[i]) begin
			coord_mem[i] = '0;
			offset_mem[i] = '0;
			coord_loaded[i] = 1'b0;
		end
		square_sum = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_and_spare_kinds();
		test_distance_vectors();
		test_update_and_offsets();
		test_accumulator_saturation();
		test_random_mix(900);
		test_back_to_back(100);

		in_valid <= 1'b0;
		while (pending_norms.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/swu_pkg.sv
hw/rtl/swu_ram.sv
hw/rtl/swu_datapath.sv
hw/rtl/swu_ctrl.sv
hw/rtl/som_weight_vector_update.sv
tb/tb_som_weight_vector_update.sv
